@@ design/swis_pkg.sv @@
// ---------------------------------------------------------------------------
// swis_pkg: shared types and constants of the sorted weighted index set
// Entry, command, cell control and gathered-result types, action and status
// codes, and the fixed field widths.
// ---------------------------------------------------------------------------
package swis_pkg;

    localparam int KEY_W = 24;
    localparam int WGT_W = 32;
    localparam int CNT_W = 25;
    localparam int RED_W = 1 + KEY_W + WGT_W;

    localparam logic [WGT_W-1:0] ONE_WORD = 32'h3F80_0000;

    typedef logic [2:0] t_action;
    localparam t_action ACT_ADD      = 3'd0;
    localparam t_action ACT_REMOVE   = 3'd1;
    localparam t_action ACT_LOOKUP   = 3'd2;
    localparam t_action ACT_READ     = 3'd3;
    localparam t_action ACT_COMPLETE = 3'd4;
    localparam t_action ACT_CLEAR    = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_IGNORED = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [WGT_W-1:0] weight;
    } t_entry;

    typedef struct packed {
        logic             match;
        logic [KEY_W-1:0] key;
        logic [WGT_W-1:0] weight;
    } t_red;

    typedef struct packed {
        t_action          action;
        logic [KEY_W-1:0] key;
        logic [WGT_W-1:0] weight;
        logic [KEY_W-1:0] position;
    } t_cmd;

    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
        logic update;
    } t_cell_ctl;

endpackage

@@ design/swis_cell.sv @@
// ---------------------------------------------------------------------------
// swis_cell: one storage cell of the sorted chain
// Holds one entry, compares it against the broadcast command, and shifts
// toward either neighbor for insert and remove.
// ---------------------------------------------------------------------------
module swis_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic                i_clk,
    input  swis_pkg::t_cmd      i_cmd,
    input  swis_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  swis_pkg::t_entry    i_left,
    input  logic                i_left_lt,
    input  swis_pkg::t_entry    i_right,
    output swis_pkg::t_entry    o_entry,
    output logic                o_lt,
    output swis_pkg::t_red      o_red
);

    swis_pkg::t_entry r_entry;
    swis_pkg::t_red   r_red;
    logic             r_lt;
    logic             r_eq;
    logic             w_valid;
    logic             w_match;

    assign w_valid = CW'(IDX) < i_count;
    assign w_match = w_valid && ((i_cmd.action == swis_pkg::ACT_READ)
                                 ? (i_cmd.position == swis_pkg::KEY_W'(IDX))
                                 : (r_entry.key == i_cmd.key));

    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            r_lt  <= w_valid && (r_entry.key < i_cmd.key);
            r_eq  <= w_valid && (r_entry.key == i_cmd.key);
            r_red <= w_match ? {1'b1, r_entry} : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (!r_lt) begin
                if (i_left_lt) begin
                    r_entry <= {i_cmd.key, i_cmd.weight};
                end else begin
                    r_entry <= i_left;
                end
            end
        end else if (i_ctl.remove) begin
            if (!r_lt) begin
                r_entry <= i_right;
            end
        end else if (i_ctl.update) begin
            if (r_eq) begin
                r_entry.weight <= i_cmd.weight;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_red   = r_red;

endmodule

@@ design/swis_or_tree.sv @@
// ---------------------------------------------------------------------------
// swis_or_tree: registered OR-reduction tree
// Gathers the single matching cell contribution through radix-16 levels,
// one register stage per level, with a valid bit traveling alongside.
// ---------------------------------------------------------------------------
module swis_or_tree #(
    parameter int N = 256,
    parameter int W = 57
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data [N],
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int Radix = 16;

    function automatic int nodes_at(input int lvl);
        int n;
        n = N;
        for (int j = 0; j <= lvl; j++) begin
            n = (n + Radix - 1) / Radix;
        end
        return n;
    endfunction

    function automatic int offset_of(input int lvl);
        int s;
        s = 0;
        for (int j = 0; j < lvl; j++) begin
            s = s + nodes_at(j);
        end
        return s;
    endfunction

    function automatic int levels_of();
        int n;
        int l;
        n = N;
        l = 0;
        for (int j = 0; j < 12; j++) begin
            if (n > 1) begin
                n = (n + Radix - 1) / Radix;
                l = l + 1;
            end
        end
        return l;
    endfunction

    localparam int LEVELS = levels_of();
    localparam int TOTAL  = offset_of(LEVELS);

    logic [W-1:0]      r_node [TOTAL];
    logic [LEVELS-1:0] r_vld;

    for (genvar lvl = 0; lvl < LEVELS; lvl++) begin : g_lvl
        localparam int PREV  = nodes_at(lvl - 1);
        localparam int BASE  = offset_of(lvl);
        localparam int PBASE = offset_of(lvl - 1);
        for (genvar nd = 0; nd < nodes_at(lvl); nd++) begin : g_node
            logic [W-1:0] w_term [Radix];
            logic [W-1:0] w_or;
            for (genvar c = 0; c < Radix; c++) begin : g_term
                if (nd * Radix + c < PREV) begin : g_used
                    if (lvl == 0) begin : g_leaf
                        assign w_term[c] = i_data[nd * Radix + c];
                    end else begin : g_inner
                        assign w_term[c] = r_node[PBASE + nd * Radix + c];
                    end
                end else begin : g_pad
                    assign w_term[c] = '0;
                end
            end
            always_comb begin
                w_or = '0;
                for (int c = 0; c < Radix; c++) begin
                    w_or = w_or | w_term[c];
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[BASE + nd] <= w_or;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= i_valid;
            for (int l = 1; l < LEVELS; l++) begin
                r_vld[l] <= r_vld[l-1];
            end
        end
    end

    assign o_valid = r_vld[LEVELS-1];
    assign o_data  = r_node[TOTAL-1];

endmodule

@@ design/sorted_weighted_index_set.sv @@
// An accepted item is registered, compared in all cells and gathered through the L radix-16
// levels of the gather tree (L = 2 at SET_DEPTH = 256); the result is then registered.
// Compare, gather and shift run one item at a time.
// The next item is taken while the previous result waits on the master side.
// Reset (synchronous, active low) empties the set and leaves complete mode; no clearing
// pass is needed, since cells at or beyond the entry count are never read.
// ---------------------------------------------------------------------------
// sorted_weighted_index_set: sorted key set with weight words
// A chain of cells keeps keys in ascending order; a command is compared in all
// cells at once, the hit is gathered by an OR tree, and cells shift locally.
// ---------------------------------------------------------------------------
module sorted_weighted_index_set #(
    parameter int SET_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key[23:0], weight_bits[55:24], position[79:56], complete_count[104:80], zero pad
    input  logic [111:0] s_tdata,
    // action[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found[0], key_out[24:1], weight_out[56:25], entry_count[81:57], status[83:82], zero pad
    output logic [87:0]  m_tdata
);

    localparam int CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_WAIT  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state                        r_state;
    swis_pkg::t_cmd                r_cmd;
    logic [swis_pkg::CNT_W-1:0]    r_ccount;
    logic [CW-1:0]                 r_count;
    logic                          r_complete;
    logic [swis_pkg::CNT_W-1:0]    r_total;
    logic                          r_red_vld;
    logic                          r_m_valid;
    logic                          r_found;
    logic [swis_pkg::KEY_W-1:0]    r_kout;
    logic [swis_pkg::WGT_W-1:0]    r_wout;
    logic [swis_pkg::CNT_W-1:0]    r_ecount;
    swis_pkg::t_status             r_status;

    t_state                        n_state;
    logic [CW-1:0]                 n_count;
    logic                          n_complete;
    logic [swis_pkg::CNT_W-1:0]    n_total;
    logic                          n_found;
    logic [swis_pkg::KEY_W-1:0]    n_kout;
    logic [swis_pkg::WGT_W-1:0]    n_wout;
    swis_pkg::t_status             n_status;

    swis_pkg::t_entry              w_entry [SET_DEPTH];
    logic                          w_lt    [SET_DEPTH];
    logic [swis_pkg::RED_W-1:0]    w_red   [SET_DEPTH];
    logic                          w_tree_vld;
    logic [swis_pkg::RED_W-1:0]    w_tree_data;
    swis_pkg::t_red                w_hit;
    swis_pkg::t_cell_ctl           w_ctl;
    logic                          w_accept;
    logic                          w_go;
    logic                          w_full;

    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_go     = (r_state == S_APPLY) && (!r_m_valid || m_tready);
    assign w_full   = (r_count == CW'(SET_DEPTH));
    assign w_hit    = swis_pkg::t_red'(w_tree_data);

    for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
        swis_pkg::t_red   w_cell_red;
        swis_pkg::t_entry w_left;
        swis_pkg::t_entry w_right;
        logic             w_left_lt;
        if (i == 0) begin : g_first
            assign w_left    = w_entry[i];
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[i-1];
            assign w_left_lt = w_lt[i-1];
        end
        if (i == SET_DEPTH - 1) begin : g_last
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end
        swis_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (r_cmd),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_entry   (w_entry[i]),
            .o_lt      (w_lt[i]),
            .o_red     (w_cell_red)
        );
        assign w_red[i] = w_cell_red;
    end

    swis_or_tree #(
        .N (SET_DEPTH),
        .W (swis_pkg::RED_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_red_vld),
        .i_data  (w_red),
        .o_valid (w_tree_vld),
        .o_data  (w_tree_data)
    );

    always_comb begin
        n_count    = r_count;
        n_complete = r_complete;
        n_total    = r_total;
        n_found    = 1'b0;
        n_kout     = '0;
        n_wout     = '0;
        n_status   = swis_pkg::ST_DONE;
        w_ctl      = '0;
        w_ctl.compare = (r_state == S_CMP);
        unique case (r_cmd.action)
            swis_pkg::ACT_ADD: begin
                n_kout = r_cmd.key;
                if (r_complete) begin
                    n_status = swis_pkg::ST_IGNORED;
                end else if (w_hit.match) begin
                    n_found      = 1'b1;
                    n_wout       = r_cmd.weight;
                    w_ctl.update = w_go;
                end else if (w_full) begin
                    n_status = swis_pkg::ST_FULL;
                end else begin
                    n_wout       = r_cmd.weight;
                    n_count      = r_count + 1'b1;
                    w_ctl.insert = w_go;
                end
            end
            swis_pkg::ACT_REMOVE: begin
                n_kout = r_cmd.key;
                if (r_complete) begin
                    n_status = swis_pkg::ST_IGNORED;
                end else if (w_hit.match) begin
                    n_found      = 1'b1;
                    n_wout       = w_hit.weight;
                    n_count      = r_count - 1'b1;
                    w_ctl.remove = w_go;
                end
            end
            swis_pkg::ACT_LOOKUP: begin
                n_kout = r_cmd.key;
                if (r_complete) begin
                    n_found = 1'b1;
                    n_wout  = swis_pkg::ONE_WORD;
                end else if (w_hit.match) begin
                    n_found = 1'b1;
                    n_wout  = w_hit.weight;
                end
            end
            swis_pkg::ACT_READ: begin
                if (r_complete) begin
                    if (swis_pkg::CNT_W'(r_cmd.position) < r_total) begin
                        n_found = 1'b1;
                        n_kout  = r_cmd.position;
                        n_wout  = swis_pkg::ONE_WORD;
                    end
                end else if (w_hit.match) begin
                    n_found = 1'b1;
                    n_kout  = w_hit.key;
                    n_wout  = w_hit.weight;
                end
            end
            swis_pkg::ACT_COMPLETE: begin
                n_complete = 1'b1;
                n_total    = r_ccount;
                n_count    = '0;
            end
            swis_pkg::ACT_CLEAR: begin
                n_complete = 1'b0;
                n_total    = '0;
                n_count    = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_tree_vld) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_complete <= 1'b0;
            r_total    <= '0;
            r_red_vld  <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_red_vld <= (r_state == S_CMP);
            if (w_go) begin
                r_count    <= n_count;
                r_complete <= n_complete;
                r_total    <= n_total;
                r_m_valid  <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.action   <= s_tuser;
            r_cmd.key      <= s_tdata[23:0];
            r_cmd.weight   <= s_tdata[55:24];
            r_cmd.position <= s_tdata[79:56];
            r_ccount       <= s_tdata[104:80];
        end
        if (w_go) begin
            r_found  <= n_found;
            r_kout   <= n_kout;
            r_wout   <= n_wout;
            r_ecount <= n_complete ? n_total : swis_pkg::CNT_W'(n_count);
            r_status <= n_status;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'b0000, r_status, r_ecount, r_wout, r_kout, r_found};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SET_DEPTH))
        else $error("entry count exceeds the set depth");

    a_complete_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_count == '0))
        else $error("entries held while in complete mode");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_complete |-> (r_total == '0))
        else $error("complete total set outside complete mode");

    a_tree_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tree_vld |-> (r_state == S_WAIT))
        else $error("gathered result arrived outside the wait state");

    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> r_m_valid && (r_state == S_IDLE))
        else $error("applied item did not produce a result");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: regression for the sorted weighted index set
// Drives add, remove, lookup, read, set-complete, clear and the spare action
// codes over the stream ports. A mirror of the set predicts every response,
// and a checker compares each response with the oldest prediction, field by
// field. Directed corner cases come first, then a fill to full depth, then
// random traffic under several idle and stall mixes and a long receiver
// hold-off.
// ---------------------------------------------------------------------------
module testbench;

    localparam int SET_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam swis_pkg::t_action ACT_SPARE6 = 3'd6;
    localparam swis_pkg::t_action ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic [swis_pkg::CNT_W-1:0] complete_count;
        logic [swis_pkg::KEY_W-1:0] position;
        logic [swis_pkg::WGT_W-1:0] weight_bits;
        logic [swis_pkg::KEY_W-1:0] key;
    } t_fields;

    typedef struct packed {
        swis_pkg::t_status          status;
        logic [swis_pkg::CNT_W-1:0] entry_count;
        logic [swis_pkg::WGT_W-1:0] weight_out;
        logic [swis_pkg::KEY_W-1:0] key_out;
        logic                       found;
    } t_response;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    logic [swis_pkg::KEY_W-1:0] mirror_keys [SET_DEPTH];
    logic [swis_pkg::WGT_W-1:0] mirror_weights [SET_DEPTH];
    int                         mirror_count = 0;
    logic                       mirror_complete = 1'b0;
    logic [swis_pkg::CNT_W-1:0] mirror_total = '0;

    t_response pending_responses [$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    sorted_weighted_index_set #(
        .SET_DEPTH(SET_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [swis_pkg::KEY_W-1:0] any_key();
        return swis_pkg::KEY_W'($urandom);
    endfunction

    function automatic logic [swis_pkg::CNT_W-1:0] any_count();
        return swis_pkg::CNT_W'($urandom);
    endfunction

    function automatic t_response predict_set_response(swis_pkg::t_action act, t_fields f);
        t_response r;
        int        slot;
        int        i;
        bit        hit;
        r = '0;
        slot = 0;
        while (slot < mirror_count && mirror_keys[slot] < f.key) slot++;
        hit = (slot < mirror_count) && (mirror_keys[slot] == f.key);
        unique case (act)
            swis_pkg::ACT_ADD: begin
                r.key_out = f.key;
                if (mirror_complete) begin
                    r.status = swis_pkg::ST_IGNORED;
                end else if (hit) begin
                    mirror_weights[slot] = f.weight_bits;
                    r.found = 1'b1;
                    r.weight_out = f.weight_bits;
                end else if (mirror_count >= SET_DEPTH) begin
                    r.status = swis_pkg::ST_FULL;
                end else begin
                    for (i = mirror_count; i > slot; i--) begin
                        mirror_keys[i] = mirror_keys[i-1];
                        mirror_weights[i] = mirror_weights[i-1];
                    end
                    mirror_keys[slot] = f.key;
                    mirror_weights[slot] = f.weight_bits;
                    mirror_count++;
                    r.weight_out = f.weight_bits;
                end
            end
            swis_pkg::ACT_REMOVE: begin
                r.key_out = f.key;
                if (mirror_complete) begin
                    r.status = swis_pkg::ST_IGNORED;
                end else if (hit) begin
                    r.found = 1'b1;
                    r.weight_out = mirror_weights[slot];
                    for (i = slot; i + 1 < mirror_count; i++) begin
                        mirror_keys[i] = mirror_keys[i+1];
                        mirror_weights[i] = mirror_weights[i+1];
                    end
                    mirror_count--;
                end
            end
            swis_pkg::ACT_LOOKUP: begin
                r.key_out = f.key;
                if (mirror_complete) begin
                    r.found = 1'b1;
                    r.weight_out = swis_pkg::ONE_WORD;
                end else if (hit) begin
                    r.found = 1'b1;
                    r.weight_out = mirror_weights[slot];
                end
            end
            swis_pkg::ACT_READ: begin
                if (mirror_complete) begin
                    if (swis_pkg::CNT_W'(f.position) < mirror_total) begin
                        r.found = 1'b1;
                        r.key_out = f.position;
                        r.weight_out = swis_pkg::ONE_WORD;
                    end
                end else if (int'(f.position) < mirror_count) begin
                    r.found = 1'b1;
                    r.key_out = mirror_keys[int'(f.position)];
                    r.weight_out = mirror_weights[int'(f.position)];
                end
            end
            swis_pkg::ACT_COMPLETE: begin
                mirror_complete = 1'b1;
                mirror_total = f.complete_count;
                mirror_count = 0;
            end
            swis_pkg::ACT_CLEAR: begin
                mirror_complete = 1'b0;
                mirror_total = '0;
                mirror_count = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = mirror_complete ? mirror_total : swis_pkg::CNT_W'(mirror_count);
        return r;
    endfunction

    function automatic t_fields random_fields();
        t_fields f;
        f.key = any_key();
        f.weight_bits = $urandom;
        f.position = any_key();
        f.complete_count = swis_pkg::CNT_W'($urandom_range(0, 32'h0100_0000));
        return f;
    endfunction

    task automatic send_item(input swis_pkg::t_action act, input t_fields f);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {7'd0, f};
        do @(posedge i_clk); while (!s_tready);
        pending_responses.push_back(predict_set_response(act, f));
    endtask

    task automatic send_fields(input swis_pkg::t_action act,
                               input logic [swis_pkg::KEY_W-1:0] key,
                               input logic [swis_pkg::WGT_W-1:0] weight,
                               input logic [swis_pkg::KEY_W-1:0] position,
                               input logic [swis_pkg::CNT_W-1:0] complete_count);
        t_fields f;
        f.key = key;
        f.weight_bits = weight;
        f.position = position;
        f.complete_count = complete_count;
        send_item(act, f);
    endtask

    task automatic wait_for_all_responses();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        t_fields           f;
        swis_pkg::t_action act;
        int                pick;
        int                base;
        f = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 40) act = swis_pkg::ACT_ADD;
        else if (pick < 55) act = swis_pkg::ACT_REMOVE;
        else if (pick < 74) act = swis_pkg::ACT_LOOKUP;
        else if (pick < 93) act = swis_pkg::ACT_READ;
        else if (pick < 94) act = swis_pkg::ACT_COMPLETE;
        else if (pick < 96) act = swis_pkg::ACT_CLEAR;
        else if (pick < 98) act = ACT_SPARE6;
        else act = ACT_SPARE7;
        pick = $urandom_range(0, 99);
        if (mirror_count > 0 && pick < 50)
            f.key = mirror_keys[$urandom_range(0, mirror_count - 1)];
        else if (pick < 80)
            f.key = swis_pkg::KEY_W'($urandom_range(0, 255));
        if (mirror_complete)
            base = (mirror_total > 25'h00F_FFFF) ? 32'h000F_FFFF : int'(mirror_total);
        else
            base = mirror_count;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f.position = swis_pkg::KEY_W'($urandom_range(0, base + 1));
        else if (pick < 70)
            f.position = swis_pkg::KEY_W'(base + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 1) == 0)
            f.complete_count = swis_pkg::CNT_W'($urandom_range(0, 600));
        send_item(act, f);
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_fields(swis_pkg::ACT_LOOKUP, 24'h00_0000, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0000, any_count());
        send_fields(swis_pkg::ACT_REMOVE, 24'hFF_FFFF, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, 24'h00_0000, 32'h0000_0000, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 25'h1FF_FFFF);
        send_fields(swis_pkg::ACT_ADD, 24'h80_0000, swis_pkg::ONE_WORD, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, 24'h00_0000, 32'hA5A5_A5A5, any_key(), any_count());
        send_fields(swis_pkg::ACT_LOOKUP, 24'h80_0000, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0000, any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0002, any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0003, any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'hFF_FFFF, any_count());
        send_fields(swis_pkg::ACT_REMOVE, 24'h80_0000, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_REMOVE, 24'h80_0000, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_LOOKUP, 24'h12_3456, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_COMPLETE, any_key(), $urandom, any_key(), 25'h100_0000);
        send_fields(swis_pkg::ACT_LOOKUP, 24'h5A_5A5A, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, 24'h00_0001, 32'h1234_5678, any_key(), any_count());
        send_fields(swis_pkg::ACT_REMOVE, 24'hFF_FFFF, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'hFF_FFFF, any_count());
        send_fields(ACT_SPARE6, any_key(), $urandom, any_key(), any_count());
        send_fields(ACT_SPARE7, any_key(), $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_COMPLETE, any_key(), $urandom, any_key(), 25'h000_0000);
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0000, any_count());
        send_fields(swis_pkg::ACT_CLEAR, any_key(), $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom, 24'h00_0000, any_count());
    endtask

    task automatic test_store_full();
        int n;
        send_idle_pct = 24;
        recv_stall_pct = 24;
        send_fields(swis_pkg::ACT_ADD, 24'h00_0000, $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, 24'hFF_FFFF, $urandom, any_key(), any_count());
        n = 0;
        while (mirror_count < SET_DEPTH) begin
            send_fields(swis_pkg::ACT_ADD, any_key(), $urandom, any_key(), any_count());
            n++;
            if (n % 8 == 0)
                send_fields(swis_pkg::ACT_LOOKUP,
                            mirror_keys[$urandom_range(0, mirror_count - 1)],
                            $urandom, any_key(), any_count());
        end
        repeat (3) send_fields(swis_pkg::ACT_ADD, any_key(), $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, mirror_keys[0], $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, mirror_keys[SET_DEPTH-1], $urandom, any_key(),
                    any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom,
                    swis_pkg::KEY_W'(SET_DEPTH - 1), any_count());
        send_fields(swis_pkg::ACT_READ, any_key(), $urandom,
                    swis_pkg::KEY_W'(SET_DEPTH), any_count());
        send_fields(swis_pkg::ACT_REMOVE, mirror_keys[$urandom_range(0, SET_DEPTH - 1)],
                    $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, any_key(), $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_ADD, any_key(), $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_LOOKUP, mirror_keys[$urandom_range(0, mirror_count - 1)],
                    $urandom, any_key(), any_count());
        send_fields(swis_pkg::ACT_CLEAR, any_key(), $urandom, any_key(), any_count());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_random_item();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (40) send_random_item();
        wait_for_all_responses();
        send_idle_pct = 24;
        recv_stall_pct = 24;
        repeat (30) send_random_item();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_store_full();
        test_random_traffic(0, 0, 170);
        test_random_traffic(58, 0, 170);
        test_random_traffic(0, 58, 170);
        test_random_traffic(24, 24, 170);
        test_backpressure();
        wait_for_all_responses();
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_response
        t_response got;
        t_response want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_response'(m_tdata[83:0]);
            if (pending_responses.size() == 0) begin
                $error("unexpected response %h with nothing pending", m_tdata);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0h, got %0h", want.found, got.found);
                    error_count++;
                end
                if (got.key_out !== want.key_out) begin
                    $error("key_out: expected %0h, got %0h", want.key_out, got.key_out);
                    error_count++;
                end
                if (got.weight_out !== want.weight_out) begin
                    $error("weight_out: expected %0h, got %0h",
                           want.weight_out, got.weight_out);
                    error_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0h, got %0h",
                           want.entry_count, got.entry_count);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0h, got %0h", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
